>>> src/mbass_pkg.sv
package mbass_pkg;

   localparam int CODE_W = 32;
   localparam int CH_W   = 5;
   localparam int BRD_W  = 3;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_TRIGGER = 2'd1,
      ACT_DISCARD = 2'd2,
      ACT_STORE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      BS_IDLE       = 3'd0,
      BS_FIRST_READ = 3'd1,
      BS_WAIT       = 3'd2,
      BS_TRIG_NEXT  = 3'd3,
      BS_STORE      = 3'd4
   } board_step_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_READ,
      SQ_DISPATCH,
      SQ_SCAN_RD,
      SQ_SCAN_EVAL,
      SQ_MED_RD0,
      SQ_MED_RD1,
      SQ_MED_RD2,
      SQ_MED_DONE,
      SQ_OUT
   } seq_state_type;

   localparam logic [2:0] REG_BOARD_KINDS = 3'd0;
   localparam logic [2:0] REG_VOLT_WAIT   = 3'd1;
   localparam logic [2:0] REG_TEMP_WAIT   = 3'd2;
   localparam logic [2:0] REG_VOLT_BUS    = 3'd3;
   localparam logic [2:0] REG_TEMP_BUS    = 3'd4;
   localparam logic [2:0] REG_FAST_PERIOD = 3'd5;
   localparam logic [2:0] REG_SLOW_PERIOD = 3'd6;

   localparam logic [1:0] KIND_VOLTAGE = 2'd1;
   localparam logic [1:0] KIND_TEMP    = 2'd2;

   typedef struct packed {
      logic                operation;
      logic [BRD_W-1:0]    board;
      logic [CODE_W-1:0]   adc_code;
      logic [CH_W-1:0]     channel;
      logic                channel_exist;
      logic                channel_in_use;
      logic                channel_fast;
   } req_type;

   typedef struct packed {
      logic [1:0]          action;
      logic [CH_W-1:0]     trigger_channel;
      logic [BRD_W-1:0]    select_code;
      logic [CH_W-1:0]     result_channel;
      logic [CODE_W-1:0]   result_code;
      logic                result_new;
   } rsp_type;

   // per-board record: step, current, next, wait count
   typedef struct packed {
      logic [2:0]  step;
      logic [4:0]  cur;
      logic [4:0]  nxt;
      logic [15:0] wcnt;
   } board_rec_type;

   // per-channel record: flags (fast, in use, exist), skip counter, median count
   typedef struct packed {
      logic [2:0] flags;
      logic [7:0] skip;
      logic [1:0] mcnt;
   } chan_rec_type;

   function automatic logic [CODE_W-1:0] median3(input logic [CODE_W-1:0] a,
                                                 input logic [CODE_W-1:0] b,
                                                 input logic [CODE_W-1:0] c);
      logic [CODE_W-1:0] lo, hi, m;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      m  = (hi < c) ? hi : c;
      return (lo > m) ? lo : m;
   endfunction

endpackage

>>> src/mbass_ram.sv
module mbass_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/multi_board_adc_scan_sequencer_top.sv
// Flow: a transaction is read (SQ_READ), dispatched (SQ_DISPATCH) and its result is
// registered in SQ_OUT; a scan probes at most CHANNELS-1 channels, a voltage store reads
// the median memory in SQ_MED_RD0 to SQ_MED_DONE. One transaction at a time, set by the
// sequential walk of the channel-record memory; a stalled result holds the next one.
// Reset: synchronous, active high; after reset a clearing pass over BOARDS*CHANNELS
// addresses zeroes the board and channel records before the first transaction is taken.
module multi_board_adc_scan_sequencer_top
   import mbass_pkg::*;
#(
   parameter int BOARDS   = 8,
   parameter int CHANNELS = 17,
   parameter int BUSES    = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wr_data
);

   localparam int BW   = (BOARDS > 1) ? $clog2(BOARDS) : 1;
   localparam int NCH  = BOARDS * CHANNELS;
   localparam int CW   = $clog2(NCH);
   localparam int MW   = $clog2(NCH * 3);

   // configuration
   logic [15:0] kinds_ff, vwait_ff, twait_ff;
   logic [1:0]  vbus_ff, tbus_ff;
   logic [7:0]  fper_ff, sper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kinds_ff <= '0; vwait_ff <= 16'd1; twait_ff <= 16'd1;
         vbus_ff <= 2'd1; tbus_ff <= 2'd0; fper_ff <= 8'd4; sper_ff <= 8'd128;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BOARD_KINDS: kinds_ff <= csr_wr_data;
            REG_VOLT_WAIT:   vwait_ff <= csr_wr_data;
            REG_TEMP_WAIT:   twait_ff <= csr_wr_data;
            REG_VOLT_BUS:    vbus_ff <= csr_wr_data[1:0];
            REG_TEMP_BUS:    tbus_ff <= csr_wr_data[1:0];
            REG_FAST_PERIOD: fper_ff <= csr_wr_data[7:0];
            REG_SLOW_PERIOD: sper_ff <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // memories
   logic              brd_we;
   logic [BW-1:0]     brd_wa, brd_ra;
   board_rec_type     brd_wd, brd_rd;
   logic              ch_we;
   logic [CW-1:0]     ch_wa, ch_ra;
   chan_rec_type      ch_wd, ch_rd;
   logic              md_we;
   logic [MW-1:0]     md_wa, md_ra;
   logic [31:0]       md_wd, md_rd;

   mbass_ram #(.WIDTH($bits(board_rec_type)), .DEPTH(BOARDS)) u_brd_ram (
      .clock(clock), .wr_en(brd_we), .wr_addr(brd_wa), .wr_data(brd_wd),
      .rd_addr(brd_ra), .rd_data(brd_rd));
   mbass_ram #(.WIDTH($bits(chan_rec_type)), .DEPTH(NCH)) u_ch_ram (
      .clock(clock), .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
      .rd_addr(ch_ra), .rd_data(ch_rd));
   mbass_ram #(.WIDTH(32), .DEPTH(NCH * 3)) u_md_ram (
      .clock(clock), .wr_en(md_we), .wr_addr(md_wa), .wr_data(md_wd),
      .rd_addr(md_ra), .rd_data(md_rd));

   // sequencer registers
   seq_state_type     st_ff, st_in;
   logic              clr_ff, clr_in;
   logic [CW:0]       clr_cnt_ff, clr_cnt_in;
   req_type           req_ff, req_in;
   board_rec_type     rec_ff, rec_in;
   logic [BUSES-1:0]  lock_ff, lock_in;
   logic [4:0]        scan_ch_ff, scan_ch_in;
   logic              scan_wrap_ff, scan_wrap_in;
   logic [31:0]       s0_ff, s0_in, s1_ff, s1_in;
   logic [CW-1:0]     cidx_ff, cidx_in;
   chan_rec_type      crec_ff, crec_in;
   rsp_type           wrk_ff, wrk_in;
   logic              out_vld_ff, out_vld_in;
   rsp_type           out_ff, out_in;

   logic [1:0]  kind;
   logic [1:0]  bus;
   logic        bus_busy;
   logic [3:0]  lock_pad;
   logic [BW-1:0] bidx;
   logic [CW-1:0] base;
   logic [15:0] wlimit;
   logic [15:0] wnext;
   logic [7:0]  skip_nx;
   logic        probe_hit;
   logic [5:0]  ch_nx;
   logic        scan_done;
   logic [31:0] med;
   logic [MW-1:0] mbase;

   assign bidx  = req_ff.board[BW-1:0];
   assign kind  = kinds_ff[{req_ff.board, 1'b0} +: 2];
   assign bus   = (kind == KIND_VOLTAGE) ? vbus_ff : tbus_ff;
   // buses past BUSES read as free
   assign lock_pad = 4'(lock_ff);
   assign bus_busy = lock_pad[bus];
   assign base  = CW'(32'(bidx) * CHANNELS);
   assign wlimit = (kind == KIND_VOLTAGE) ? vwait_ff : twait_ff;
   assign wnext = (rec_ff.wcnt == 16'hFFFF) ? rec_ff.wcnt : rec_ff.wcnt + 16'd1;
   assign skip_nx = (ch_rd.skip == 8'hFF) ? ch_rd.skip : ch_rd.skip + 8'd1;
   assign mbase = MW'(32'(cidx_ff) * 3);
   assign med = median3(s0_ff, s1_ff, req_ff.adc_code);

   always_comb begin
      probe_hit = 1'b0;
      if (ch_rd.flags[0]) begin
         if (ch_rd.flags[1]) begin
            probe_hit = 1'b1;
         end else begin
            probe_hit = skip_nx >= (ch_rd.flags[2] ? fper_ff : sper_ff);
         end
      end
   end

   // next scan channel; second half stops at cur
   always_comb begin
      ch_nx = {1'b0, scan_ch_ff} + 6'd1;
      scan_done = 1'b0;
      if (!scan_wrap_ff && ch_nx >= 6'(CHANNELS)) begin
         ch_nx = 6'd0;
      end
      if ((scan_wrap_ff || ch_nx == 6'd0) && ch_nx >= {1'b0, rec_ff.cur}) begin
         scan_done = 1'b1;
      end
   end

   assign req_stall = (st_ff != SQ_IDLE) || clr_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   function automatic rsp_type blank_rsp(input logic [2:0] b);
      rsp_type r;
      r = '0;
      r.select_code = 3'd7 - b;
      return r;
   endfunction

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         SQ_IDLE: begin
            if (req_valid && !clr_ff) st_in = SQ_READ;
         end
         SQ_READ:  st_in = SQ_DISPATCH;
         SQ_DISPATCH: begin
            if (req_ff.operation || {29'd0, req_ff.board} >= BOARDS
                || kind == 2'd0 || kind == 2'd3) begin
               st_in = SQ_OUT;
            end else if (rec_ff.step == BS_TRIG_NEXT && !bus_busy) begin
               st_in = SQ_SCAN_RD;
            end else if (rec_ff.step == BS_STORE && req_ff.adc_code != '0
                         && {27'd0, rec_ff.cur} < CHANNELS && kind == KIND_VOLTAGE) begin
               st_in = SQ_MED_RD0;
            end else begin
               st_in = SQ_OUT;
            end
         end
         SQ_SCAN_RD: begin
            // nothing to probe when the scan range is empty
            if (scan_wrap_ff && scan_ch_ff >= rec_ff.cur) st_in = SQ_OUT;
            else st_in = SQ_SCAN_EVAL;
         end
         SQ_SCAN_EVAL: begin
            if (probe_hit || scan_done) st_in = SQ_OUT;
            else st_in = SQ_SCAN_EVAL;
         end
         SQ_MED_RD0: st_in = SQ_MED_RD1;
         SQ_MED_RD1: st_in = SQ_MED_RD2;
         SQ_MED_RD2: st_in = SQ_MED_DONE;
         SQ_MED_DONE: st_in = SQ_OUT;
         SQ_OUT: begin
            if (!out_vld_ff || !rsp_stall) st_in = SQ_IDLE;
         end
         default: st_in = SQ_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      req_in = req_ff;
      rec_in = rec_ff;
      lock_in = lock_ff;
      scan_ch_in = scan_ch_ff;
      scan_wrap_in = scan_wrap_ff;
      s0_in = s0_ff;
      s1_in = s1_ff;
      cidx_in = cidx_ff;
      crec_in = crec_ff;
      wrk_in = wrk_ff;
      out_in = out_ff;
      out_vld_in = out_vld_ff;
      brd_we = 1'b0; brd_wa = bidx; brd_wd = rec_ff; brd_ra = bidx;
      ch_we = 1'b0; ch_wa = cidx_ff; ch_wd = crec_ff; ch_ra = cidx_ff;
      md_we = 1'b0; md_wa = mbase; md_wd = req_ff.adc_code; md_ra = mbase;

      if (out_vld_ff && !rsp_stall) out_vld_in = 1'b0;

      if (clr_ff) begin
         brd_we = 1'b1; brd_wa = clr_cnt_ff[BW-1:0]; brd_wd = '0;
         ch_we = 1'b1; ch_wa = clr_cnt_ff[CW-1:0]; ch_wd = '0;
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == (CW+1)'(NCH - 1)) clr_in = 1'b0;
      end

      case (st_ff)
         SQ_IDLE: begin
            if (req_valid && !clr_ff) begin
               req_in = req_data;
               brd_ra = req_data.board[BW-1:0];
            end
         end
         SQ_READ: begin
            rec_in = brd_rd;
            cidx_in = CW'(32'(bidx) * CHANNELS + 32'(brd_rd.cur));
            ch_ra = CW'(32'(bidx) * CHANNELS + 32'(brd_rd.cur));
            // settings write keeps the median count of its channel
            if (req_ff.operation) ch_ra = CW'(32'(bidx) * CHANNELS + 32'(req_ff.channel));
         end
         SQ_DISPATCH: begin
            wrk_in = blank_rsp(req_ff.board);
            crec_in = ch_rd;
            if (req_ff.operation) begin
               if ({29'd0, req_ff.board} < BOARDS && {27'd0, req_ff.channel} < CHANNELS) begin
                  ch_we = 1'b1;
                  ch_wa = CW'(32'(bidx) * CHANNELS + 32'(req_ff.channel));
                  ch_wd = ch_rd;
                  ch_wd.skip = '0;
                  ch_wd.flags = {req_ff.channel_fast, req_ff.channel_in_use,
                                 req_ff.channel_exist};
               end
            end else if ({29'd0, req_ff.board} < BOARDS && kind != 2'd0 && kind != 2'd3) begin
               case (rec_ff.step)
                  BS_IDLE: begin
                     if (!bus_busy) begin
                        if ({30'd0, bus} < BUSES) lock_in[bus] = 1'b1;
                        wrk_in.action = ACT_TRIGGER;
                        brd_we = 1'b1;
                        brd_wd = '0;
                        brd_wd.wcnt = rec_ff.wcnt;
                        brd_wd.step = BS_FIRST_READ;
                     end
                  end
                  BS_FIRST_READ: begin
                     wrk_in.action = ACT_DISCARD;
                     if ({30'd0, bus} < BUSES) lock_in[bus] = 1'b0;
                     brd_we = 1'b1;
                     brd_wd.step = BS_WAIT;
                  end
                  BS_WAIT: begin
                     brd_we = 1'b1;
                     brd_wd.wcnt = wnext;
                     if (wnext >= wlimit) begin
                        brd_wd.wcnt = '0;
                        brd_wd.step = BS_TRIG_NEXT;
                     end
                  end
                  BS_TRIG_NEXT: begin
                     if (!bus_busy) begin
                        if ({30'd0, bus} < BUSES) lock_in[bus] = 1'b1;
                        wrk_in.action = ACT_TRIGGER;
                        rec_in.nxt = rec_ff.cur;
                        if ({1'b0, rec_ff.cur} + 6'd1 >= 6'(CHANNELS)) begin
                           scan_ch_in = 5'd0;
                           scan_wrap_in = 1'b1;
                        end else begin
                           scan_ch_in = rec_ff.cur + 5'd1;
                           scan_wrap_in = 1'b0;
                        end
                     end
                  end
                  BS_STORE: begin
                     wrk_in.action = ACT_STORE;
                     wrk_in.result_channel = rec_ff.cur;
                     if ({30'd0, bus} < BUSES) lock_in[bus] = 1'b0;
                     if (req_ff.adc_code != '0 && {27'd0, rec_ff.cur} < CHANNELS
                         && kind == KIND_TEMP) begin
                        wrk_in.result_code = req_ff.adc_code;
                        wrk_in.result_new = 1'b1;
                     end
                     brd_we = 1'b1;
                     brd_wd.cur = rec_ff.nxt;
                     brd_wd.step = BS_WAIT;
                  end
                  default: begin
                     brd_we = 1'b1;
                     brd_wd.step = BS_IDLE;
                  end
               endcase
            end
         end
         SQ_SCAN_RD: begin
            cidx_in = base + CW'(scan_ch_ff);
            ch_ra = base + CW'(scan_ch_ff);
         end
         SQ_SCAN_EVAL: begin
            if (ch_rd.flags[0] && !ch_rd.flags[1]) begin
               ch_we = 1'b1;
               ch_wd = ch_rd;
               ch_wd.skip = probe_hit ? 8'd0 : skip_nx;
            end
            if (probe_hit) begin
               rec_in.nxt = scan_ch_ff;
            end else if (!scan_done) begin
               scan_ch_in = ch_nx[4:0];
               if (ch_nx == 6'd0) scan_wrap_in = 1'b1;
               cidx_in = base + CW'(ch_nx[4:0]);
               ch_ra = base + CW'(ch_nx[4:0]);
            end
         end
         SQ_MED_RD0: begin
            md_ra = mbase;
         end
         SQ_MED_RD1: begin
            md_ra = mbase + MW'(1);
         end
         SQ_MED_RD2: begin
            s0_in = md_rd;
         end
         SQ_MED_DONE: begin
            s1_in = md_rd;
            if (crec_ff.mcnt >= 2'd2) begin
               md_we = 1'b1; md_wa = mbase + MW'(2);
               ch_we = 1'b1; ch_wd = crec_ff; ch_wd.mcnt = 2'd0;
            end else begin
               md_we = 1'b1; md_wa = mbase + MW'(crec_ff.mcnt);
               ch_we = 1'b1; ch_wd = crec_ff; ch_wd.mcnt = crec_ff.mcnt + 2'd1;
            end
         end
         SQ_OUT: begin
            if (!out_vld_ff || !rsp_stall) begin
               out_vld_in = 1'b1;
               out_in = wrk_ff;
               if (rec_ff.step == BS_STORE && kind == KIND_VOLTAGE && !req_ff.operation
                   && {29'd0, req_ff.board} < BOARDS
                   && req_ff.adc_code != '0 && {27'd0, rec_ff.cur} < CHANNELS
                   && crec_ff.mcnt >= 2'd2) begin
                  out_in.result_code = med;
                  out_in.result_new = 1'b1;
               end
               if (rec_ff.step == BS_TRIG_NEXT && wrk_ff.action == ACT_TRIGGER
                   && !req_ff.operation) begin
                  out_in.trigger_channel = rec_ff.nxt;
                  brd_we = 1'b1;
                  brd_wd = rec_ff;
                  brd_wd.step = BS_STORE;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SQ_IDLE;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         lock_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         lock_ff <= lock_in;
         out_vld_ff <= out_vld_in;
      end
      req_ff <= req_in;
      rec_ff <= rec_in;
      scan_ch_ff <= scan_ch_in;
      scan_wrap_ff <= scan_wrap_in;
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      cidx_ff <= cidx_in;
      crec_ff <= crec_in;
      wrk_ff <= wrk_in;
      out_ff <= out_in;
   end

endmodule

>>> tb/multi_board_adc_scan_sequencer_top_tb.sv
module multi_board_adc_scan_sequencer_top_tb;
   import mbass_pkg::*;

   localparam int BOARDS     = 8;
   localparam int CHANNELS   = 17;
   localparam int BUSES      = 3;
   localparam int DRAIN      = 2 * CHANNELS + 16;
   localparam int CYCLE_CAP  = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = REG_BOARD_KINDS;
   logic [15:0] csr_wr_data = '0;

   multi_board_adc_scan_sequencer_top #(
      .BOARDS(BOARDS), .CHANNELS(CHANNELS), .BUSES(BUSES)
   ) dut (.*);

   // scan state mirrored from the block
   logic [15:0]    kinds_reg, volt_wait_reg, temp_wait_reg;
   logic [1:0]     volt_bus_reg, temp_bus_reg;
   logic [7:0]     fast_per_reg, slow_per_reg;
   board_step_type step_of [BOARDS];
   logic [4:0]     cur_ch [BOARDS];
   logic [4:0]     nxt_ch [BOARDS];
   logic [15:0]    wait_cnt [BOARDS];
   logic           bus_held [BUSES];
   logic [2:0]     ch_flags [BOARDS*CHANNELS];
   logic [7:0]     skip_cnt [BOARDS*CHANNELS];
   logic [31:0]    med_buf [BOARDS*CHANNELS*3];
   logic [1:0]     med_cnt [BOARDS*CHANNELS];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   bit      req_taken = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit bus_busy(int bus);
      return (bus < BUSES) ? bus_held[bus] : 1'b0;
   endfunction

   function automatic void bus_mark(int bus, logic v);
      if (bus < BUSES) bus_held[bus] = v;
   endfunction

   function automatic bit channel_due(int idx);
      logic [7:0] period;
      if (!ch_flags[idx][0]) return 0;
      if (ch_flags[idx][1]) return 1;
      period = ch_flags[idx][2] ? fast_per_reg : slow_per_reg;
      if (skip_cnt[idx] < 8'd255) skip_cnt[idx]++;
      if (skip_cnt[idx] >= period) begin
         skip_cnt[idx] = 8'd0;
         return 1;
      end
      return 0;
   endfunction

   function automatic logic [4:0] scan_next(int b);
      int cur, lim;
      cur = cur_ch[b];
      for (int ch = cur + 1; ch < CHANNELS; ch++)
         if (channel_due(b*CHANNELS + ch)) return 5'(ch);
      lim = (cur < CHANNELS) ? cur : CHANNELS;
      for (int ch = 0; ch < lim; ch++)
         if (channel_due(b*CHANNELS + ch)) return 5'(ch);
      return 5'(cur);
   endfunction

   function automatic rsp_type predict_scan_step(req_type r);
      rsp_type     o;
      int          b, ch, kind, bus, cur, idx, n;
      logic [15:0] lim;
      logic [31:0] lo, hi, m, a0, a1, a2;
      o = '0;
      o.select_code = 3'd7 - r.board;
      b = r.board;
      ch = r.channel;
      if (r.operation) begin
         if (ch < CHANNELS) begin
            idx = b*CHANNELS + ch;
            ch_flags[idx] = {r.channel_fast, r.channel_in_use, r.channel_exist};
            skip_cnt[idx] = 8'd0;
         end
         return o;
      end
      kind = kinds_reg[2*b +: 2];
      if (kind != KIND_VOLTAGE && kind != KIND_TEMP) return o;
      bus = (kind == KIND_VOLTAGE) ? volt_bus_reg : temp_bus_reg;
      case (step_of[b])
         BS_IDLE: begin
            if (!bus_busy(bus)) begin
               bus_mark(bus, 1);
               nxt_ch[b] = 5'd0;
               cur_ch[b] = 5'd0;
               o.action = ACT_TRIGGER;
               step_of[b] = BS_FIRST_READ;
            end
         end
         BS_FIRST_READ: begin
            o.action = ACT_DISCARD;
            bus_mark(bus, 0);
            step_of[b] = BS_WAIT;
         end
         BS_WAIT: begin
            lim = (kind == KIND_VOLTAGE) ? volt_wait_reg : temp_wait_reg;
            if (wait_cnt[b] < 16'hFFFF) wait_cnt[b]++;
            if (wait_cnt[b] >= lim) begin
               wait_cnt[b] = 16'd0;
               step_of[b] = BS_TRIG_NEXT;
            end
         end
         BS_TRIG_NEXT: begin
            if (!bus_busy(bus)) begin
               bus_mark(bus, 1);
               nxt_ch[b] = scan_next(b);
               o.action = ACT_TRIGGER;
               o.trigger_channel = nxt_ch[b];
               step_of[b] = BS_STORE;
            end
         end
         BS_STORE: begin
            cur = cur_ch[b];
            o.action = ACT_STORE;
            o.result_channel = 5'(cur);
            if (r.adc_code != 0 && cur < CHANNELS) begin
               idx = b*CHANNELS + cur;
               if (kind == KIND_TEMP) begin
                  o.result_code = r.adc_code;
                  o.result_new = 1;
               end else begin
                  n = (med_cnt[idx] > 2) ? 2 : med_cnt[idx];
                  med_buf[idx*3 + n] = r.adc_code;
                  if (n == 2) begin
                     a0 = med_buf[idx*3];
                     a1 = med_buf[idx*3 + 1];
                     a2 = med_buf[idx*3 + 2];
                     lo = (a0 < a1) ? a0 : a1;
                     hi = (a0 < a1) ? a1 : a0;
                     m  = (hi < a2) ? hi : a2;
                     o.result_code = (lo > m) ? lo : m;
                     o.result_new = 1;
                     med_cnt[idx] = 2'd0;
                  end else begin
                     med_cnt[idx] = 2'(n + 1);
                  end
               end
            end
            bus_mark(bus, 0);
            cur_ch[b] = nxt_ch[b];
            step_of[b] = BS_WAIT;
         end
         default: step_of[b] = BS_IDLE;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   function automatic bit gap_now();
      if (cycle_count > 30000 && cycle_count < 60000) return 0;
      return $urandom_range(99) < 11;
   endfunction

   // accept side and prediction
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) expected_rsps.push_back(predict_scan_step(req_data));
      if (cycle_count > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() > 0 && !gap_now()) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= gap_now();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.action !== want.action)
               report_mismatch($sformatf("action %0d want %0d",
                                         rsp_data.action, want.action));
            if (rsp_data.trigger_channel !== want.trigger_channel)
               report_mismatch($sformatf("trigger_channel %0d want %0d",
                                         rsp_data.trigger_channel, want.trigger_channel));
            if (rsp_data.select_code !== want.select_code)
               report_mismatch($sformatf("select_code %0d want %0d",
                                         rsp_data.select_code, want.select_code));
            if (rsp_data.result_channel !== want.result_channel)
               report_mismatch($sformatf("result_channel %0d want %0d",
                                         rsp_data.result_channel, want.result_channel));
            if (rsp_data.result_code !== want.result_code)
               report_mismatch($sformatf("result_code %h want %h",
                                         rsp_data.result_code, want.result_code));
            if (rsp_data.result_new !== want.result_new)
               report_mismatch($sformatf("result_new %0d want %0d",
                                         rsp_data.result_new, want.result_new));
         end
      end
   end

   task automatic wait_quiet();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wr_data <= value;
      case (index)
         REG_BOARD_KINDS: kinds_reg = value;
         REG_VOLT_WAIT:   volt_wait_reg = value;
         REG_TEMP_WAIT:   temp_wait_reg = value;
         REG_VOLT_BUS:    volt_bus_reg = value[1:0];
         REG_TEMP_BUS:    temp_bus_reg = value[1:0];
         REG_FAST_PERIOD: fast_per_reg = value[7:0];
         REG_SLOW_PERIOD: slow_per_reg = value[7:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(logic [15:0] kinds, logic [15:0] vw, logic [15:0] tw,
                           logic [1:0] vb, logic [1:0] tb, logic [7:0] fp,
                           logic [7:0] sp);
      csr_write(REG_BOARD_KINDS, kinds);
      csr_write(REG_VOLT_WAIT, vw);
      csr_write(REG_TEMP_WAIT, tw);
      csr_write(REG_VOLT_BUS, {14'd0, vb});
      csr_write(REG_TEMP_BUS, {14'd0, tb});
      csr_write(REG_FAST_PERIOD, {8'd0, fp});
      csr_write(REG_SLOW_PERIOD, {8'd0, sp});
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type settings_item(int b, int ch, bit ex, bit busy, bit fast);
      req_type r;
      r = '0;
      r.operation = 1;
      r.board = 3'(b);
      r.adc_code = $urandom;
      r.channel = 5'(ch);
      r.channel_exist = ex;
      r.channel_in_use = busy;
      r.channel_fast = fast;
      return r;
   endfunction

   function automatic req_type visit_item(int b, logic [31:0] code);
      req_type r;
      r = '0;
      r.board = 3'(b);
      r.adc_code = code;
      r.channel = 5'($urandom_range(31));
      {r.channel_exist, r.channel_in_use, r.channel_fast} = 3'($urandom_range(7));
      return r;
   endfunction

   function automatic logic [31:0] rand_code();
      case ($urandom_range(9))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(3) + 1;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      int sel;
      // populate channel tables so the scan has something to find
      repeat (24)
         pending_reqs.push_back(settings_item($urandom_range(7), $urandom_range(16),
                                              $urandom_range(99) < 80,
                                              $urandom_range(99) < 20, $urandom_range(1)));
      repeat (count) begin
         sel = $urandom_range(99);
         if (sel < 10)
            pending_reqs.push_back(settings_item($urandom_range(7), $urandom_range(16),
                                                 $urandom_range(1), $urandom_range(99) < 25,
                                                 $urandom_range(1)));
         else if (sel < 13)
            pending_reqs.push_back(settings_item($urandom_range(7), $urandom_range(31),
                                                 $urandom_range(1), $urandom_range(1),
                                                 $urandom_range(1)));
         else
            pending_reqs.push_back(visit_item($urandom_range(7), rand_code()));
      end
   endtask

   initial begin
      kinds_reg = 0; volt_wait_reg = 1; temp_wait_reg = 1;
      volt_bus_reg = 1; temp_bus_reg = 0; fast_per_reg = 4; slow_per_reg = 128;
      for (int b = 0; b < BOARDS; b++) begin
         step_of[b] = BS_IDLE; cur_ch[b] = 0; nxt_ch[b] = 0; wait_cnt[b] = 0;
      end
      for (int i = 0; i < BUSES; i++) bus_held[i] = 0;
      for (int i = 0; i < BOARDS*CHANNELS; i++) begin
         ch_flags[i] = 0; skip_cnt[i] = 0; med_cnt[i] = 0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      // hold off until the clearing pass is done
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // boards 0,2 voltage; 1,4 temperature; 3 reserved kind; rest unused
      set_regs(16'b00_00_00_10_11_01_10_01, 16'd2, 16'd1, 2'd1, 2'd0, 8'd1, 8'd2);
      pending_reqs.push_back(settings_item(0, 0, 1, 1, 0));
      pending_reqs.push_back(settings_item(0, 16, 1, 0, 1));
      pending_reqs.push_back(settings_item(1, 5, 1, 0, 0));
      pending_reqs.push_back(settings_item(7, 31, 1, 1, 1));
      pending_reqs.push_back(settings_item(2, 17, 1, 1, 1));
      pending_reqs.push_back(visit_item(3, 32'h1234));
      pending_reqs.push_back(visit_item(5, 32'h1));
      pending_reqs.push_back(visit_item(0, 32'h5));
      pending_reqs.push_back(visit_item(2, 32'h6));
      pending_reqs.push_back(visit_item(0, 32'h7));
      pending_reqs.push_back(visit_item(1, 32'h8));
      pending_reqs.push_back(visit_item(4, 32'h9));
      pending_reqs.push_back(visit_item(1, 32'h10));
      for (int k = 0; k < 12; k++)
         pending_reqs.push_back(visit_item(k % 2 ? 1 : 0,
            (k == 4) ? 32'h0 : (k == 6) ? 32'hFFFF_FFFF : (k % 3) * 32'h100 + 1));
      wait_quiet();

      set_regs(16'hFFFF, 16'd1, 16'd1, 2'd3, 2'd2, 8'd1, 8'd1);
      random_phase(250);
      wait_quiet();
      set_regs(16'h5555, 16'd3, 16'd65535, 2'd2, 2'd2, 8'd255, 8'd255);
      random_phase(250);
      wait_quiet();
      set_regs(16'hAAAA, 16'd65535, 16'd2, 2'd0, 2'd1, 8'd3, 8'd5);
      random_phase(250);
      wait_quiet();
      set_regs(16'h6969, 16'd1, 16'd3, 2'd1, 2'd1, 8'd2, 8'd7);
      random_phase(300);
      wait_quiet();
      set_regs(16'($urandom), 16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
               2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom_range(6, 1)),
               8'($urandom_range(12, 1)));
      random_phase(300);
      wait_quiet();
      set_regs(16'b01_10_01_10_01_10_01_10, 16'd1, 16'd1, 2'd0, 2'd0, 8'd4, 8'd128);
      random_phase(250);
      wait_quiet();

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
